### hw/rtl/tlcd_pkg.sv
// ----------------------------------------------------------------------------
// tlcd_pkg
// Shared types and constants of the two-line crossing detector: word layouts,
// register indexes, state and action codes, and the widths of the shared
// multiplier datapath.
// ----------------------------------------------------------------------------
package tlcd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FOOT_W     = COORD_BITS + 2;
  localparam int LINE_W     = 16;
  localparam int PT_W       = (FOOT_W > LINE_W) ? FOOT_W : LINE_W;
  localparam int DIF_W      = PT_W + 1;
  localparam int CR_W       = DIF_W + LINE_W + 1;
  localparam int NUM_W      = 2 * CR_W;
  localparam int DEN_W      = 2 * LINE_W + 2;
  localparam int SQ_W       = 2 * DIF_W;

  localparam int MA_W   = NUM_W;
  localparam int MB_W   = CR_W;
  localparam int DIG_W  = 4;
  localparam int NDIG   = (MB_W + DIG_W - 1) / DIG_W;
  localparam int PROD_W = MA_W + MB_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_EN  = 3'd4;

  localparam logic [1:0] ST_OFF   = 2'd0;
  localparam logic [1:0] ST_NOREF = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;
  localparam logic [1:0] ST_IN    = 2'd3;

  localparam logic [1:0] ACT_OFF    = 2'd0;
  localparam logic [1:0] ACT_NONE   = 2'd1;
  localparam logic [1:0] ACT_IN_OUT = 2'd2;
  localparam logic [1:0] ACT_OUT_IN = 2'd3;

  localparam logic [1:0] ORI_COL = 2'd0;
  localparam logic [1:0] ORI_CW  = 2'd1;
  localparam logic [1:0] ORI_CCW = 2'd2;

  typedef struct packed {
    logic                          restart;
    logic signed [COORD_BITS-1:0]  box_left;
    logic signed [COORD_BITS-1:0]  box_top;
    logic        [COORD_BITS-1:0]  box_width;
    logic        [COORD_BITS-1:0]  box_height;
  } in_word_t;

  typedef struct packed {
    logic [1:0] crossing_state;
    logic [1:0] crossing_action;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] p;
  } mul_rsp_t;

endpackage

### hw/rtl/tlcd_mul.sv
// ----------------------------------------------------------------------------
// tlcd_mul
// Digit-serial unsigned multiplier: one 4-bit digit of b per cycle is
// multiplied with the shifted a and added into the product.
// ----------------------------------------------------------------------------
module tlcd_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  tlcd_pkg::mul_req_t req,
  output tlcd_pkg::mul_rsp_t rsp
);
  import tlcd_pkg::*;

  localparam int CNT_W = $clog2(NDIG + 1);
  localparam int BR_W  = NDIG * DIG_W;

  logic [PROD_W-1:0]       acc_r, acc_nxt, a_r, a_nxt;
  logic [BR_W-1:0]         b_r, b_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt, done_r, done_nxt;
  logic [PROD_W+DIG_W-1:0] pp;

  always_comb begin
    pp       = a_r * b_r[DIG_W-1:0];
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      a_nxt    = PROD_W'(req.a);
      b_nxt    = BR_W'(req.b);
      cnt_nxt  = CNT_W'(NDIG);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp[PROD_W-1:0];
      a_nxt   = a_r << DIG_W;
      b_nxt   = b_r >> DIG_W;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

### hw/rtl/two_line_crossing_detector_core.sv
// ----------------------------------------------------------------------------
// two_line_crossing_detector_core
// Tripwire detector: per box word forms the foot point and, with lines enabled and a
// previous point, tests the motion segment against the out and in lines and updates line state and action.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one box word per frame; out_valid/
//   out_ready/out_data return one state/action word for each box word.
//   cfg_we/cfg_index/cfg_wdata write the line endpoints and the enable while
//   the block is idle.
// Timing:
//   One word at a time; in_ready is high only while idle. Lines off or the
//   first frame of a track: the word goes straight to S_DONE, which sets
//   out_valid once the output register is free. Otherwise 16 orientation
//   products run in turn (NDIG = 9 digits each); both lines hit adds 24
//   distance and compare products. in_ready returns with out_valid. All
//   orientation, distance and compare products share the one digit-serial multiplier.
// Reset:
//   Configuration, control, line state, action and track history clear to zero; datapath and output data are not reset.
// Stall:
//   A result waits in the output register until taken; the next box word is
//   accepted meanwhile, and its own result waits for the register to free.
// ----------------------------------------------------------------------------
module two_line_crossing_detector_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tlcd_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tlcd_pkg::out_word_t                out_data,
  input  logic                               cfg_we,
  input  logic [tlcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlcd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tlcd_pkg::*;

  localparam int SP_W  = PROD_W + 1;
  localparam int OPA_W = MA_W + 1;
  localparam int OPB_W = MB_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_HIT   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [5:0] STEP_ORI_LAST = 6'd15;
  localparam logic [5:0] STEP_DIST     = 6'd16;
  localparam logic [5:0] STEP_CMP      = 6'd38;
  localparam logic [5:0] STEP_LAST     = 6'd39;
  localparam logic [5:0] DIST_STEPS    = 6'd11;

  function automatic logic signed [DIF_W-1:0] dif(input logic signed [PT_W-1:0] a,
                                                  input logic signed [PT_W-1:0] b);
    dif = DIF_W'(a) - DIF_W'(b);
  endfunction

  function automatic logic in_box(input logic signed [PT_W-1:0] qx,
                                  input logic signed [PT_W-1:0] qy,
                                  input logic signed [PT_W-1:0] px,
                                  input logic signed [PT_W-1:0] py,
                                  input logic signed [PT_W-1:0] rx,
                                  input logic signed [PT_W-1:0] ry);
    in_box = (qx <= ((px > rx) ? px : rx)) && (qx >= ((px < rx) ? px : rx)) &&
             (qy <= ((py > ry) ? py : ry)) && (qy >= ((py < ry) ? py : ry));
  endfunction

  function automatic logic [1:0] ori_code(input logic signed [SP_W-1:0] v);
    if (v == '0) ori_code = ORI_COL;
    else if (!v[SP_W-1]) ori_code = ORI_CW;
    else ori_code = ORI_CCW;
  endfunction

  // configuration and history
  logic [CFG_DATA_W-1:0] out_s_r, out_e_r, in_s_r, in_e_r;
  logic                  en_r;
  logic [1:0]            state_r, state_nxt, action_r, action_nxt, frames_r, frames_nxt;
  logic [FOOT_W-1:0]     prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;

  // sequencer
  logic [2:0] fsm_r, fsm_nxt;
  logic [5:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;

  // datapath
  logic signed [PT_W-1:0] px_r, px_nxt, py_r, py_nxt, qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [SP_W-1:0] acc_r, acc_nxt;
  logic [1:0]             ocode_r [0:7];
  logic [1:0]             ocode_nxt [0:7];
  logic signed [CR_W-1:0] dot_r, dot_nxt, cr_r, cr_nxt;
  logic [DEN_W-1:0]       d2_r, d2_nxt;
  logic [SQ_W-1:0]        uu_r, uu_nxt, vv_r, vv_nxt;
  logic [NUM_W-1:0]       num_r [0:1];
  logic [NUM_W-1:0]       num_nxt [0:1];
  logic [DEN_W-1:0]       den_r [0:1];
  logic [DEN_W-1:0]       den_nxt [0:1];
  logic                   neg_r, neg_nxt;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic in_fire;
  logic [1:0] fr_eff;
  logic signed [FOOT_W-1:0] cur_x, cur_y;

  logic signed [PT_W-1:0] ox0, oy0, ox1, oy1, ix0, iy0, ix1, iy1;
  logic signed [PT_W-1:0] l0x, l0y, l1x, l1y;
  logic signed [PT_W-1:0] ptpx, ptpy, ptqx, ptqy, ptrx, ptry;
  logic signed [DIF_W-1:0] dxv, dyv, uxv, uyv, vxv, vyv;
  logic [5:0] dstep;
  logic       dist_l, line_sel;
  logic [3:0] dj;
  logic [CR_W-1:0] cr_abs;
  logic signed [OPA_W-1:0] op_a, op_a_abs;
  logic signed [OPB_W-1:0] op_b, op_b_abs;
  logic [SP_W-1:0] p_ext;
  logic signed [SP_W-1:0] sprod, sum_v, diff_v;
  logic ho, hi;

  tlcd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign in_ready  = (fsm_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur_x = FOOT_W'(in_data.box_left) + FOOT_W'({1'b0, in_data.box_width[COORD_BITS-1:1]});
  assign cur_y = FOOT_W'(in_data.box_top) + FOOT_W'({1'b0, in_data.box_height});
  assign fr_eff = in_data.restart ? 2'd0 : frames_r;

  assign ox0 = PT_W'($signed(out_s_r[31:16]));
  assign oy0 = PT_W'($signed(out_s_r[15:0]));
  assign ox1 = PT_W'($signed(out_e_r[31:16]));
  assign oy1 = PT_W'($signed(out_e_r[15:0]));
  assign ix0 = PT_W'($signed(in_s_r[31:16]));
  assign iy0 = PT_W'($signed(in_s_r[15:0]));
  assign ix1 = PT_W'($signed(in_e_r[31:16]));
  assign iy1 = PT_W'($signed(in_e_r[15:0]));

  assign dstep    = step_r - STEP_DIST;
  assign dist_l   = (dstep >= DIST_STEPS);
  assign dj       = dist_l ? 4'(dstep - DIST_STEPS) : dstep[3:0];
  assign line_sel = (step_r < STEP_DIST) ? step_r[3] : dist_l;

  assign l0x = line_sel ? ix0 : ox0;
  assign l0y = line_sel ? iy0 : oy0;
  assign l1x = line_sel ? ix1 : ox1;
  assign l1y = line_sel ? iy1 : oy1;

  always_comb begin
    ptpx = px_r; ptpy = py_r; ptqx = qx_r; ptqy = qy_r; ptrx = l0x; ptry = l0y;
    case (step_r[2:1])
      2'd0: begin
        ptpx = l0x; ptpy = l0y; ptqx = l1x; ptqy = l1y; ptrx = px_r; ptry = py_r;
      end
      2'd1: begin
        ptpx = l0x; ptpy = l0y; ptqx = l1x; ptqy = l1y; ptrx = qx_r; ptry = qy_r;
      end
      2'd2: begin
        ptrx = l0x; ptry = l0y;
      end
      default: begin
        ptrx = l1x; ptry = l1y;
      end
    endcase
  end

  assign dxv = dif(l1x, l0x);
  assign dyv = dif(l1y, l0y);
  assign uxv = dif(px_r, l0x);
  assign uyv = dif(py_r, l0y);
  assign vxv = dif(px_r, l1x);
  assign vyv = dif(py_r, l1y);
  assign cr_abs = cr_r[CR_W-1] ? CR_W'(-cr_r) : CR_W'(cr_r);

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (step_r < STEP_DIST) begin
      if (!step_r[0]) begin
        op_a = OPA_W'(dif(ptqy, ptpy));
        op_b = OPB_W'(dif(ptrx, ptqx));
      end else begin
        op_a = OPA_W'(dif(ptqx, ptpx));
        op_b = OPB_W'(dif(ptry, ptqy));
      end
    end else if (step_r < STEP_CMP) begin
      case (dj)
        4'd0: begin op_a = OPA_W'(dxv); op_b = OPB_W'(uxv); end
        4'd1: begin op_a = OPA_W'(dyv); op_b = OPB_W'(uyv); end
        4'd2: begin op_a = OPA_W'(dxv); op_b = OPB_W'(dxv); end
        4'd3: begin op_a = OPA_W'(dyv); op_b = OPB_W'(dyv); end
        4'd4: begin op_a = OPA_W'(uxv); op_b = OPB_W'(uxv); end
        4'd5: begin op_a = OPA_W'(uyv); op_b = OPB_W'(uyv); end
        4'd6: begin op_a = OPA_W'(vxv); op_b = OPB_W'(vxv); end
        4'd7: begin op_a = OPA_W'(vyv); op_b = OPB_W'(vyv); end
        4'd8: begin op_a = OPA_W'(dxv); op_b = OPB_W'(uyv); end
        4'd9: begin op_a = OPA_W'(dyv); op_b = OPB_W'(uxv); end
        default: begin
          op_a = OPA_W'({1'b0, cr_abs});
          op_b = OPB_W'({1'b0, cr_abs});
        end
      endcase
    end else if (step_r == STEP_CMP) begin
      op_a = OPA_W'({1'b0, num_r[0]});
      op_b = OPB_W'({1'b0, den_r[1]});
    end else begin
      op_a = OPA_W'({1'b0, num_r[1]});
      op_b = OPB_W'({1'b0, den_r[0]});
    end
  end

  assign op_a_abs   = op_a[OPA_W-1] ? -op_a : op_a;
  assign op_b_abs   = op_b[OPB_W-1] ? -op_b : op_b;
  assign mreq.start = (fsm_r == S_ISSUE);
  assign mreq.a     = op_a_abs[MA_W-1:0];
  assign mreq.b     = op_b_abs[MB_W-1:0];

  assign p_ext  = {1'b0, mrsp.p};
  assign sprod  = neg_r ? -$signed(p_ext) : $signed(p_ext);
  assign sum_v  = acc_r + sprod;
  assign diff_v = acc_r - sprod;

  always_comb begin
    ho = (ocode_r[0] != ocode_r[1] && ocode_r[2] != ocode_r[3]) ||
         (ocode_r[0] == ORI_COL && in_box(px_r, py_r, ox0, oy0, ox1, oy1)) ||
         (ocode_r[1] == ORI_COL && in_box(qx_r, qy_r, ox0, oy0, ox1, oy1)) ||
         (ocode_r[2] == ORI_COL && in_box(ox0, oy0, px_r, py_r, qx_r, qy_r)) ||
         (ocode_r[3] == ORI_COL && in_box(ox1, oy1, px_r, py_r, qx_r, qy_r));
    hi = (ocode_r[4] != ocode_r[5] && ocode_r[6] != ocode_r[7]) ||
         (ocode_r[4] == ORI_COL && in_box(px_r, py_r, ix0, iy0, ix1, iy1)) ||
         (ocode_r[5] == ORI_COL && in_box(qx_r, qy_r, ix0, iy0, ix1, iy1)) ||
         (ocode_r[6] == ORI_COL && in_box(ix0, iy0, px_r, py_r, qx_r, qy_r)) ||
         (ocode_r[7] == ORI_COL && in_box(ix1, iy1, px_r, py_r, qx_r, qy_r));
  end

  always_comb begin
    fsm_nxt       = fsm_r;
    step_nxt      = step_r;
    state_nxt     = state_r;
    action_nxt    = action_r;
    frames_nxt    = frames_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    px_nxt = px_r; py_nxt = py_r; qx_nxt = qx_r; qy_nxt = qy_r;
    acc_nxt = acc_r;
    ocode_nxt = ocode_r;
    dot_nxt = dot_r; cr_nxt = cr_r; d2_nxt = d2_r; uu_nxt = uu_r; vv_nxt = vv_r;
    num_nxt = num_r;
    den_nxt = den_r;
    neg_nxt = neg_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (fsm_r)
      S_IDLE: begin
        if (in_fire) begin
          frames_nxt = (fr_eff == 2'd0) ? 2'd1 : 2'd2;
          prev_x_nxt = cur_x;
          prev_y_nxt = cur_y;
          qx_nxt = PT_W'(cur_x);
          qy_nxt = PT_W'(cur_y);
          px_nxt = (fr_eff == 2'd2) ? PT_W'($signed(prev_x_r)) : PT_W'(cur_x);
          py_nxt = (fr_eff == 2'd2) ? PT_W'($signed(prev_y_r)) : PT_W'(cur_y);
          step_nxt = '0;
          if (!en_r) begin
            state_nxt  = ST_OFF;
            action_nxt = ACT_OFF;
            fsm_nxt    = S_DONE;
          end else if (fr_eff == 2'd0) begin
            state_nxt = ST_NOREF;
            fsm_nxt   = S_DONE;
          end else begin
            fsm_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        neg_nxt = op_a[OPA_W-1] ^ op_b[OPB_W-1];
        fsm_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mrsp.done) begin
          fsm_nxt  = S_ISSUE;
          step_nxt = step_r + 1'b1;
          if (step_r < STEP_DIST) begin
            if (!step_r[0]) acc_nxt = sprod;
            else ocode_nxt[step_r[3:1]] = ori_code(diff_v);
            if (step_r == STEP_ORI_LAST) fsm_nxt = S_HIT;
          end else if (step_r < STEP_CMP) begin
            case (dj)
              4'd1: dot_nxt = sum_v[CR_W-1:0];
              4'd3: d2_nxt  = sum_v[DEN_W-1:0];
              4'd5: uu_nxt  = sum_v[SQ_W-1:0];
              4'd7: vv_nxt  = sum_v[SQ_W-1:0];
              4'd9: cr_nxt  = diff_v[CR_W-1:0];
              4'd10: begin
                if (dot_r <= 0) begin
                  num_nxt[dist_l] = NUM_W'(uu_r);
                  den_nxt[dist_l] = DEN_W'(1);
                end else if (dot_r >= $signed({1'b0, d2_r})) begin
                  num_nxt[dist_l] = NUM_W'(vv_r);
                  den_nxt[dist_l] = DEN_W'(1);
                end else begin
                  num_nxt[dist_l] = sprod[NUM_W-1:0];
                  den_nxt[dist_l] = d2_r;
                end
              end
              default: acc_nxt = sprod;
            endcase
          end else if (step_r == STEP_CMP) begin
            acc_nxt = sprod;
          end else begin
            if (acc_r < sprod) begin
              state_nxt  = ST_IN;
              action_nxt = ACT_OUT_IN;
            end else begin
              state_nxt  = ST_OUT;
              action_nxt = ACT_IN_OUT;
            end
            fsm_nxt = S_DONE;
          end
          if (step_r == STEP_LAST) fsm_nxt = S_DONE;
        end
      end
      S_HIT: begin
        fsm_nxt = S_DONE;
        if (ho && hi) begin
          step_nxt = STEP_DIST;
          fsm_nxt  = S_ISSUE;
        end else if (ho) begin
          action_nxt = (state_r == ST_IN) ? ACT_IN_OUT : ACT_NONE;
          state_nxt  = ST_OUT;
        end else if (hi) begin
          action_nxt = (state_r == ST_OUT) ? ACT_OUT_IN : ACT_NONE;
          state_nxt  = ST_IN;
        end else begin
          action_nxt = ACT_NONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.crossing_state  = state_r;
          out_data_nxt.crossing_action = action_r;
          fsm_nxt                      = S_IDLE;
        end
      end
      default: fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_s_r     <= '0;
      out_e_r     <= '0;
      in_s_r      <= '0;
      in_e_r      <= '0;
      en_r        <= 1'b0;
      state_r     <= ST_OFF;
      action_r    <= ACT_OFF;
      frames_r    <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      fsm_r       <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OUT_START: out_s_r <= cfg_wdata;
          CFG_OUT_END:   out_e_r <= cfg_wdata;
          CFG_IN_START:  in_s_r  <= cfg_wdata;
          CFG_IN_END:    in_e_r  <= cfg_wdata;
          CFG_LINES_EN:  en_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      action_r    <= action_nxt;
      frames_r    <= frames_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      fsm_r       <= fsm_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    acc_r      <= acc_nxt;
    ocode_r    <= ocode_nxt;
    dot_r      <= dot_nxt;
    cr_r       <= cr_nxt;
    d2_r       <= d2_nxt;
    uu_r       <= uu_nxt;
    vv_r       <= vv_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    neg_r      <= neg_nxt;
  end

endmodule
